FILE: rtl/vhpc_pkg.sv
package vhpc_pkg;

  // action codes
  localparam logic [1:0] ACT_ADD   = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // store select for a read
  localparam logic [1:0] SEL_AXIAL  = 2'd0;
  localparam logic [1:0] SEL_RADIAL = 2'd1;
  localparam logic [1:0] SEL_SPEED  = 2'd2;

  // speed unit: one step per cycle, sqrt runs in the first half of the divide
  localparam int unsigned DIV_STEPS = 64;
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned STEP_W = $clog2(DIV_STEPS);

  localparam logic [31:0] SCALE_RESET = 32'h0001_0000;

  typedef struct packed {
    logic        done;
    logic [31:0] speed;
    logic [63:0] weight;
  } spd_rsp_t;

endpackage

FILE: rtl/vhpc_speed_unit.sv
module vhpc_speed_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [63:0]       v2_i,
  output vhpc_pkg::spd_rsp_t rsp_o
);
  import vhpc_pkg::*;

  logic              run_q;
  logic [STEP_W-1:0] cnt_q;
  logic              done_q;
  logic [63:0]       xs_q;
  logic [33:0]       srem_q;
  logic [31:0]       root_q;
  logic [63:0]       v_q;
  logic [63:0]       drem_q;
  logic [63:0]       quot_q;
  logic              small_q;
  logic              pow2_q;

  logic [34:0] srem_n;
  logic [34:0] trial;
  logic [64:0] drem_n;
  logic        sqrt_act;

  assign sqrt_act = 32'(cnt_q) < SQRT_STEPS;
  assign srem_n   = {srem_q[32:0], xs_q[63:62]};
  assign trial    = {1'b0, root_q, 2'b01};
  assign drem_n   = {drem_q, 1'b1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + STEP_W'(1);
        if (cnt_q == STEP_W'(DIV_STEPS - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      xs_q    <= v2_i;
      srem_q  <= '0;
      root_q  <= '0;
      v_q     <= v2_i;
      drem_q  <= '0;
      quot_q  <= '0;
      small_q <= v2_i < 64'd2;
      pow2_q  <= (v2_i & (v2_i - 64'd1)) == 64'd0;
    end else if (run_q) begin
      // restoring divide of all-ones by V, one quotient bit a cycle
      if (drem_n >= {1'b0, v_q}) begin
        drem_q <= 64'(drem_n - {1'b0, v_q});
        quot_q <= {quot_q[62:0], 1'b1};
      end else begin
        drem_q <= drem_n[63:0];
        quot_q <= {quot_q[62:0], 1'b0};
      end
      // digit-by-digit square root, two radicand bits a cycle
      if (sqrt_act) begin
        xs_q <= {xs_q[61:0], 2'b00};
        if (srem_n >= trial) begin
          srem_q <= 34'(srem_n - trial);
          root_q <= {root_q[30:0], 1'b1};
        end else begin
          srem_q <= srem_n[33:0];
          root_q <= {root_q[30:0], 1'b0};
        end
      end
    end
  end

  // floor((2^64-1)/V), plus one when V is a power of two; V of 0 or 1 saturates
  assign rsp_o.done   = done_q;
  assign rsp_o.speed  = root_q;
  assign rsp_o.weight = small_q ? '1 : quot_q + {63'd0, pow2_q};

endmodule

FILE: rtl/velocity_histogram_per_cell.sv
// Per-cell velocity histogram. Issue a transfer with start high while busy is
// low: action 0 adds one particle, 1 clears all stores, 2 reads one bin.
// Particles in an odd cell or off the grid are dropped. A read returns its
// bin on read_value_o, flagged by result_valid_o for exactly one cycle; the
// receiver cannot stall, so it must take the value in that cycle. Add and
// clear return nothing.
// An add keeps busy high until its bin update is written, so no transfer is
// taken until it is through. Its time is set by the 64-step divider for the
// 1/v^2 weight (the square root runs alongside it); five products share one
// 32x32 multiplier ahead of it, and the scaled speed uses it after. The bin
// update is a read-modify-write of the three stores. A read reads them in
// ST_READ and registers the result in ST_READ_OUT. A clear sweeps the stores
// one entry a cycle: (GRID_ROWS/2)*(GRID_COLS/2)*NBINS entries, 16384 at the
// defaults; the same sweep runs after reset, with busy high. velocity_scale
// may be written at any time the block is idle, also during that sweep.
module velocity_histogram_per_cell #(
  parameter int unsigned NBINS     = 64,
  parameter int unsigned GRID_ROWS = 32,
  parameter int unsigned GRID_COLS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action_i,
  input  logic [4:0]  cell_row_i,
  input  logic [4:0]  cell_col_i,
  input  logic [31:0] vel_axial_i,
  input  logic [31:0] vel_radial_i,
  input  logic [31:0] vel_azimuthal_i,
  input  logic [3:0]  read_row_i,
  input  logic [3:0]  read_col_i,
  input  logic [5:0]  read_bin_i,
  input  logic [1:0]  read_which_i,
  input  logic        velocity_scale_we_i,
  input  logic [31:0] velocity_scale_i,
  output logic        result_valid_o,
  output logic [63:0] read_value_o
);
  import vhpc_pkg::*;

  localparam int unsigned HALF_ROWS  = GRID_ROWS / 2;
  localparam int unsigned HALF_COLS  = GRID_COLS / 2;
  localparam int unsigned CELLS      = HALF_ROWS * HALF_COLS;
  localparam int unsigned DEPTH      = CELLS * NBINS;
  localparam int unsigned AW         = $clog2(DEPTH);
  localparam int unsigned CW         = $clog2(CELLS + 1);
  localparam int unsigned BW         = $clog2(NBINS);
  localparam int unsigned BIN_OFFSET = NBINS / 2;

  // quick reject: beyond this the bin is out of range for either sign
  localparam logic [67:0] REJECT =
      (((68'(BIN_OFFSET) + 68'd8) << 32) / 68'd8) + (68'd52 << 32);
  localparam logic [67:0] NEG_EDGE = 68'(BIN_OFFSET + 1) << 32;
  localparam logic [36:0] BO_W     = 37'(BIN_OFFSET);
  localparam logic [36:0] NB_W     = 37'(NBINS);

  typedef enum logic [9:0] {
    ST_IDLE     = 10'b00_0000_0001,
    ST_CLEAR    = 10'b00_0000_0010,
    ST_MUL      = 10'b00_0000_0100,
    ST_SPEED    = 10'b00_0000_1000,
    ST_SMUL     = 10'b00_0001_0000,
    ST_BIN      = 10'b00_0010_0000,
    ST_RMW_RD   = 10'b00_0100_0000,
    ST_RMW_WR   = 10'b00_1000_0000,
    ST_READ     = 10'b01_0000_0000,
    ST_READ_OUT = 10'b10_0000_0000
  } state_e;

  typedef struct packed {
    logic          ok;
    logic [BW-1:0] bin;
  } bin_res_t;

  // trunc(10*x + NBINS/2) with x = +-prod/2^32
  function automatic bin_res_t find_bin(input logic [63:0] prod, input logic neg);
    logic [67:0] a;
    logic [35:0] ip;
    logic [36:0] ceilv;
    bin_res_t    r;
    a       = ({4'd0, prod} << 3) + ({4'd0, prod} << 1);
    ip      = a[67:32];
    ceilv   = {1'b0, ip} + {36'd0, (a[31:0] != 32'd0)};
    r.ok    = 1'b0;
    r.bin   = '0;
    if ({4'd0, prod} < REJECT) begin
      if (!neg) begin
        if ({1'b0, ip} + BO_W < NB_W) begin
          r.ok  = 1'b1;
          r.bin = BW'({1'b0, ip} + BO_W);
        end
      end else if (ceilv <= BO_W) begin
        r.ok  = 1'b1;
        r.bin = BW'(BO_W - ceilv);
      end else if (a < NEG_EDGE) begin
        r.ok  = 1'b1;  // slightly negative bin truncates to zero
      end
    end
    return r;
  endfunction

  state_e      state_q, state_d;
  logic [31:0] scale_q;
  logic [AW-1:0] clr_q;
  logic [2:0]  mstep_q;

  logic [CW-1:0] cell_q;
  logic [31:0] mz_q, mr_q, mt_q;
  logic        nz_q, nr_q;
  logic [63:0] prod_z_q, prod_r_q, v2_q, mul_q;
  logic [63:0] weight_q;
  logic [31:0] speed_q;
  logic [AW-1:0] addr_z_q, addr_r_q, addr_s_q;
  logic        ok_z_q, ok_r_q, ok_s_q;

  logic [AW-1:0] rd_addr_q;
  logic        rd_ok_q;
  logic [1:0]  rd_which_q;

  logic        valid_q;
  logic [63:0] value_q;

  logic [31:0] mul_a, mul_b;
  logic        accept;
  logic        cell_even, cell_in;
  logic [3:0]  half_row, half_col;
  logic        spd_start;
  logic [63:0] spd_v2;
  spd_rsp_t    spd_rsp;
  bin_res_t    bz, br, bs;

  logic [31:0] mem_z [DEPTH];
  logic [31:0] mem_r [DEPTH];
  logic [63:0] mem_s [DEPTH];
  logic [31:0] rd_z_q, rd_r_q;
  logic [63:0] rd_s_q;
  logic [AW-1:0] ra_z, ra_r, ra_s, wa_z, wa_r, wa_s;
  logic        we_z, we_r, we_s;
  logic [31:0] wd_z, wd_r;
  logic [63:0] wd_s;
  logic [64:0] sum_s;

  assign accept    = start && (state_q == ST_IDLE);
  assign busy      = state_q != ST_IDLE;
  assign half_row  = cell_row_i[4:1];
  assign half_col  = cell_col_i[4:1];
  assign cell_even = !cell_row_i[0] && !cell_col_i[0];
  assign cell_in   = (32'(half_row) < HALF_ROWS) && (32'(half_col) < HALF_COLS);

  // shared multiplier: axial, radial and speed scaling, and the three squares
  always_comb begin
    mul_a = speed_q;
    mul_b = scale_q;
    if (state_q == ST_MUL) begin
      unique case (mstep_q)
        3'd0:    begin mul_a = mz_q; mul_b = scale_q; end
        3'd1:    begin mul_a = mr_q; mul_b = scale_q; end
        3'd2:    begin mul_a = mz_q; mul_b = mz_q; end
        3'd3:    begin mul_a = mr_q; mul_b = mr_q; end
        3'd4:    begin mul_a = mt_q; mul_b = mt_q; end
        default: begin mul_a = mt_q; mul_b = mt_q; end
      endcase
    end
  end

  assign spd_start = (state_q == ST_MUL) && (mstep_q == 3'd5);
  assign spd_v2    = v2_q + mul_q;

  vhpc_speed_unit u_speed (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (spd_start),
    .v2_i    (spd_v2),
    .rsp_o   (spd_rsp)
  );

  assign bz = find_bin(prod_z_q, nz_q);
  assign br = find_bin(prod_r_q, nr_q);
  assign bs = find_bin(mul_q, 1'b0);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          priority if (action_i == ACT_ADD) begin
            if (cell_even && cell_in) state_d = ST_MUL;
          end else if (action_i == ACT_CLEAR) begin
            state_d = ST_CLEAR;
          end else if (action_i == ACT_READ) begin
            state_d = ST_READ;
          end
        end
      end
      ST_CLEAR:    if (clr_q == AW'(DEPTH - 1)) state_d = ST_IDLE;
      ST_MUL:      if (mstep_q == 3'd5) state_d = ST_SPEED;
      ST_SPEED:    if (spd_rsp.done) state_d = ST_SMUL;
      ST_SMUL:     state_d = ST_BIN;
      ST_BIN:      state_d = ST_RMW_RD;
      ST_RMW_RD:   state_d = ST_RMW_WR;
      ST_RMW_WR:   state_d = ST_IDLE;
      ST_READ:     state_d = ST_READ_OUT;
      ST_READ_OUT: state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      mstep_q <= '0;
      scale_q <= SCALE_RESET;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= state_q == ST_READ_OUT;
      if (velocity_scale_we_i) scale_q <= velocity_scale_i;
      if (state_q == ST_CLEAR) clr_q <= clr_q + AW'(1);
      else clr_q <= '0;
      if (state_q == ST_MUL) mstep_q <= mstep_q + 3'd1;
      else mstep_q <= '0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    mul_q <= {32'd0, mul_a} * {32'd0, mul_b};
    if (accept) begin
      cell_q     <= CW'(32'(half_row) * HALF_COLS + 32'(half_col));
      mz_q       <= vel_axial_i[31] ? 32'(0 - vel_axial_i) : vel_axial_i;
      mr_q       <= vel_radial_i[31] ? 32'(0 - vel_radial_i) : vel_radial_i;
      mt_q       <= vel_azimuthal_i[31] ? 32'(0 - vel_azimuthal_i) : vel_azimuthal_i;
      nz_q       <= vel_axial_i[31];
      nr_q       <= vel_radial_i[31];
      rd_addr_q  <= AW'((32'(read_row_i) * HALF_COLS + 32'(read_col_i)) * NBINS
                        + 32'(read_bin_i));
      rd_ok_q    <= (32'(read_row_i) < HALF_ROWS) && (32'(read_col_i) < HALF_COLS)
                    && (32'(read_bin_i) < NBINS) && (read_which_i != 2'd3);
      rd_which_q <= read_which_i;
    end
    if (state_q == ST_MUL) begin
      unique case (mstep_q)
        3'd1:    prod_z_q <= mul_q;
        3'd2:    prod_r_q <= mul_q;
        3'd3:    v2_q <= mul_q;
        3'd4:    v2_q <= v2_q + mul_q;
        default: ;
      endcase
    end
    if ((state_q == ST_SPEED) && spd_rsp.done) begin
      speed_q  <= spd_rsp.speed;
      weight_q <= spd_rsp.weight;
    end
    if (state_q == ST_BIN) begin
      addr_z_q <= AW'(32'(cell_q) * NBINS + 32'(bz.bin));
      addr_r_q <= AW'(32'(cell_q) * NBINS + 32'(br.bin));
      addr_s_q <= AW'(32'(cell_q) * NBINS + 32'(bs.bin));
      ok_z_q   <= bz.ok;
      ok_r_q   <= br.ok;
      ok_s_q   <= bs.ok;
    end
    if (state_q == ST_READ_OUT) begin
      value_q <= '0;
      if (rd_ok_q) begin
        unique case (rd_which_q)
          SEL_AXIAL:  value_q <= {32'd0, rd_z_q};
          SEL_RADIAL: value_q <= {32'd0, rd_r_q};
          SEL_SPEED:  value_q <= rd_s_q;
          default:    value_q <= '0;
        endcase
      end
    end
  end

  // store ports: the sequencer never overlaps a read-modify-write with another
  assign ra_z = (state_q == ST_READ) ? rd_addr_q : addr_z_q;
  assign ra_r = (state_q == ST_READ) ? rd_addr_q : addr_r_q;
  assign ra_s = (state_q == ST_READ) ? rd_addr_q : addr_s_q;

  assign sum_s = {1'b0, rd_s_q} + {1'b0, weight_q};

  always_comb begin
    we_z = 1'b0;
    we_r = 1'b0;
    we_s = 1'b0;
    wa_z = addr_z_q;
    wa_r = addr_r_q;
    wa_s = addr_s_q;
    wd_z = (rd_z_q == '1) ? rd_z_q : rd_z_q + 32'd1;
    wd_r = (rd_r_q == '1) ? rd_r_q : rd_r_q + 32'd1;
    wd_s = sum_s[64] ? '1 : sum_s[63:0];
    if (state_q == ST_CLEAR) begin
      we_z = 1'b1;
      we_r = 1'b1;
      we_s = 1'b1;
      wa_z = clr_q;
      wa_r = clr_q;
      wa_s = clr_q;
      wd_z = '0;
      wd_r = '0;
      wd_s = '0;
    end else if (state_q == ST_RMW_WR) begin
      we_z = ok_z_q;
      we_r = ok_r_q;
      we_s = ok_s_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_z) mem_z[wa_z] <= wd_z;
    rd_z_q <= mem_z[ra_z];
  end

  always_ff @(posedge clk_i) begin
    if (we_r) mem_r[wa_r] <= wd_r;
    rd_r_q <= mem_r[ra_r];
  end

  always_ff @(posedge clk_i) begin
    if (we_s) mem_s[wa_s] <= wd_s;
    rd_s_q <= mem_s[ra_s];
  end

  assign result_valid_o = valid_q;
  assign read_value_o   = value_q;

  a_valid_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == ST_READ_OUT))
    else $error("result without a read");

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we_z || we_r || we_s) |-> (state_q == ST_CLEAR || state_q == ST_RMW_WR))
    else $error("store written outside clear or update");

  a_speed_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    spd_rsp.done |-> (state_q == ST_SPEED))
    else $error("speed unit finished while not awaited");

  a_start_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    spd_start |=> !spd_start)
    else $error("speed unit started twice");

endmodule
